@@ rtl/core/stbs_pkg.sv @@
`default_nettype none

package stbs_pkg;

  // Field widths of the item channels and the configuration register.
  localparam int SLOT_W  = 10;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  // Operation codes carried in the op field.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register index of entry_count (taken from paddr bit 2).
  localparam logic REG_ENTRY_COUNT = 1'b0;

  // One request item: a table write or a search.
  typedef struct packed {
    logic                    op;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // One result item of a search.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/stbs_front.sv @@
`default_nettype none

module stbs_front
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      q_valid,
  output req_t      q_item,
  input  wire logic q_pop
);

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  logic       pop;

  // A write to a slot beyond the table is dropped here and never queued.
  assign keep = (req.op == OP_SEARCH) || (32'(req.slot) < DEPTH32);

  assign req_ready = (count != 2'd2);
  assign push      = req_valid && req_ready && keep;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = entries[rd_ptr];

  // Two-entry queue between the accept side and the table engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");

  a_drop_no_push: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !keep && !pop) |=> $stable(count))
    else $error("dropped write changed the queue");
`endif

endmodule

`default_nettype wire

@@ rtl/core/stbs_back.sv @@
`default_nettype none

module stbs_back
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COUNT_W-1:0] entry_count,
  input  wire logic               q_valid,
  input  wire req_t               q_item,
  output logic                    q_pop,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output rsp_t                    rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
  localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PROBE = 1'b1;

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] key;
  logic                   state;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [AW-1:0]          mid;

  logic                   state_next;
  logic [CW-1:0]          lo_next;
  logic [CW-1:0]          hi_next;
  logic [AW-1:0]          mid_next;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic                   start;
  logic                   res_fire;
  logic                   res_found;
  logic [POS_W-1:0]       res_pos;
  logic                   slot_free;

  logic [63:0]            value_ext;
  logic [VALUE_WIDTH-1:0] head_key;
  logic [31:0]            cnt_ext;
  logic [CW-1:0]          n;
  logic [CW-1:0]          n_m1;
  logic [AW-1:0]          start_mid;
  logic [CW-1:0]          mid_ext;
  logic [CW-1:0]          mid_p1;
  logic [CW-1:0]          span_up;
  logic [CW-1:0]          span_dn;
  logic [AW-1:0]          mid_up;
  logic [AW-1:0]          mid_dn;

  // Keys are stored with the sign bit flipped so unsigned order is signed order.
  assign value_ext = {32'd0, q_item.value};
  assign head_key  = value_ext[VALUE_WIDTH-1:0] ^ SIGN_FLIP;

  // Search length saturates at the table depth.
  assign cnt_ext   = 32'(entry_count);
  assign n         = (cnt_ext > DEPTH32) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);
  assign n_m1      = n - CW'(1);
  assign start_mid = AW'(n_m1 >> 1);

  // Both candidate probes for the next step are prepared in parallel with the compare.
  assign mid_ext = CW'(mid);
  assign mid_p1  = mid_ext + CW'(1);
  assign span_up = hi - mid_p1 - CW'(1);
  assign span_dn = mid_ext - lo - CW'(1);
  assign mid_up  = AW'(mid_p1 + (span_up >> 1));
  assign mid_dn  = AW'(lo + (span_dn >> 1));

  assign slot_free = !rsp_valid || rsp_ready;

  // Step control: write, answer a search with an empty table, start a search, or take one probe result.
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    rd_addr    = mid;
    mem_we     = 1'b0;
    start      = 1'b0;
    q_pop      = 1'b0;
    res_fire   = 1'b0;
    res_found  = 1'b0;
    res_pos    = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_WRITE) begin
            mem_we = 1'b1;
            q_pop  = 1'b1;
          end else if (n == '0) begin
            if (slot_free) begin
              q_pop    = 1'b1;
              res_fire = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            start      = 1'b1;
            state_next = ST_PROBE;
            lo_next    = '0;
            hi_next    = n;
            mid_next   = start_mid;
            rd_addr    = start_mid;
          end
        end
      end
      ST_PROBE: begin
        if (slot_free) begin
          if (rdata == key) begin
            res_fire   = 1'b1;
            res_found  = 1'b1;
            res_pos    = POS_W'(mid);
            state_next = ST_IDLE;
          end else if (rdata < key) begin
            if (mid_p1 >= hi) begin
              res_fire   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              lo_next  = mid_p1;
              mid_next = mid_up;
              rd_addr  = mid_up;
            end
          end else begin
            if (mid_ext == lo) begin
              res_fire   = 1'b1;
              state_next = ST_IDLE;
            end else begin
              hi_next  = mid_ext;
              mid_next = mid_dn;
              rd_addr  = mid_dn;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Search window, target key and result payload.
  always_ff @(posedge clk) begin
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    if (start) begin
      key <= head_key;
    end
    if (res_fire) begin
      rsp.found    <= res_found;
      rsp.position <= res_pos;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_item.slot)] <= head_key;
    end
    rdata <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_window_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (lo < hi))
    else $error("search window empty while probing");

  a_mid_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((mid_ext >= lo) && (mid_ext < hi)))
    else $error("probe outside search window");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.position == '0))
    else $error("miss reported a nonzero position");
`endif

endmodule

`default_nettype wire

@@ rtl/core/sorted_table_binary_search_top.sv @@
// A write is queued and is written to the table when the idle engine takes it from the queue;
// a search is taken from the queue and probes at most P = floor(log2(N)) + 1 entries,
// where N is entry_count saturated at TABLE_DEPTH, one table read per probe, before its
// result is registered. Writes go one per cycle while the engine is idle; a search holds
// the engine until its result is registered, and a result waits on rsp_ready. Reset (rst,
// synchronous) clears entry_count, the queue and the result valid flag; the table is not cleared.
`default_nettype none

module sorted_table_binary_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp
);

  logic [COUNT_W-1:0] entry_count;
  logic               cfg_write;
  logic               q_valid;
  req_t               q_item;
  logic               q_pop;

  // Configuration register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write && (paddr[2] == REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRY_COUNT) begin
      prdata = 32'(entry_count);
    end
  end

  // Accept side with its item queue.
  stbs_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Table memory and search engine.
  stbs_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .entry_count(entry_count),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

@@ test/tb_sorted_table_binary_search_top.sv @@
`timescale 1ns / 100ps

module tb_sorted_table_binary_search_top;
  import stbs_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int QUIET_PHASE   = 6;
  localparam int HOLD_PHASE    = 7;
  localparam int NUM_PHASES    = 9;

  localparam longint VALUE_MIN = -64'sd2147483648;
  localparam longint VALUE_MAX = 64'sd2147483647;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] COUNT_ADDR      = {REG_ENTRY_COUNT, 2'b00};
  localparam logic [2:0] UNUSED_REG_ADDR = {~REG_ENTRY_COUNT, 2'b00};

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_COUNT, ROW_UNUSED_REG} row_kind_t;

  // One row of the directed stimulus; typed rows carry their own expected result.
  typedef struct packed {
    row_kind_t               kind;
    logic                    op;
    logic [SLOT_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
    logic                    typed;
    rsp_t                    typed_rsp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;

  // Shadow of the block: table contents, the entry count and outstanding searches.
  logic signed [VAL_W-1:0] loaded_values [TABLE_DEPTH];
  logic [COUNT_W-1:0]      entry_count_now = '0;
  rsp_t                    search_outcomes [$];
  stim_row_t               directed_rows [$];

  int mismatches  = 0;
  int cycles      = 0;
  int phase_no    = -1;
  bit sender_idles = 1'b1;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  sorted_table_binary_search_top dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sorted_table_binary_search_top regression: fail");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  // Binary search over the shadow table, probing low + (high - low) / 2.
  function automatic rsp_t search_outcome(input logic signed [VAL_W-1:0] target);
    int   span;
    int   lo;
    int   hi;
    int   mid;
    rsp_t hit;
    hit = '0;
    span = (entry_count_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_now);
    lo = 0;
    hi = span - 1;
    while (lo <= hi && !hit.found) begin
      mid = lo + (hi - lo) / 2;
      if (loaded_values[mid] == target) begin
        hit.found = 1'b1;
        hit.position = mid[POS_W-1:0];
      end else if (loaded_values[mid] < target) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  function automatic void add_row(input row_kind_t kind, input logic op, input int slot,
                                  input longint value, input int typed,
                                  input int found, input int pos);
    stim_row_t row;
    row.kind = kind;
    row.op = op;
    row.slot = slot[SLOT_W-1:0];
    row.value = 32'(value);
    row.typed = (typed != 0);
    row.typed_rsp.found = (found != 0);
    row.typed_rsp.position = pos[POS_W-1:0];
    directed_rows = {directed_rows, row};
  endfunction

  // Offer one item, with random idle cycles before it while sender_idles is set, and update the shadow on acceptance.
  task automatic offer_item(input req_t item, input logic typed, input rsp_t typed_rsp);
    rsp_t due;
    while (sender_idles && $urandom_range(99) < 36) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.op == OP_SEARCH) begin
      due = typed ? typed_rsp : search_outcome(item.value);
      search_outcomes = {search_outcomes, due};
    end else begin
      loaded_values[item.slot] = item.value;
    end
  endtask

  // Register write once the block is idle, followed by a read back of entry_count.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    req_valid <= 1'b0;
    while (search_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == COUNT_ADDR) entry_count_now = data[COUNT_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= COUNT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_W-1:0] !== entry_count_now) begin
      flag_mismatch($sformatf("entry_count read back: expected %0d, got %0d",
                              entry_count_now, prdata[COUNT_W-1:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random back-pressure, none in the quiet phase, one long hold-off, and the comparison.
  always @(posedge clk) begin : drain
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (search_outcomes.size() == 0) begin
          flag_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                  rsp.found, rsp.position));
        end else begin
          want = search_outcomes.pop_front();
          if (rsp.found !== want.found) begin
            flag_mismatch($sformatf("found: expected %0b, got %0b", want.found, rsp.found));
          end
          if (rsp.position !== want.position) begin
            flag_mismatch($sformatf("position: expected %0d, got %0d",
                                    want.position, rsp.position));
          end
        end
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (phase_no == HOLD_PHASE && !hold_done) begin
        rsp_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (phase_no == QUIET_PHASE) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    stim_row_t row;
    req_t      item;
    rsp_t      no_rsp;
    longint    lo_v;
    longint    hi_v;
    longint    pick;
    int        eff;
    int        n_items;
    int        s;
    logic [COUNT_W-1:0] phase_count;

    no_rsp = '0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_valid <= 1'b0;
    req <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: count zero, extremes, equal entries, an unsorted table and
    // a write to a register that does not exist.
    add_row(ROW_ITEM, OP_SEARCH, 0, 0, 1, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 1023, VALUE_MIN, 1, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 0, VALUE_MIN, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 1, -1, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 2, 0, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 3, VALUE_MAX, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 1023, 64'h5555_5555, 0, 0, 0);
    add_row(ROW_UNUSED_REG, OP_WRITE, 0, 3, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MIN, 1, 0, 0);
    add_row(ROW_SET_COUNT, OP_WRITE, 0, 1, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MIN, 1, 1, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MAX, 1, 0, 0);
    add_row(ROW_SET_COUNT, OP_WRITE, 0, 4, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MIN, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, -1, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MAX, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, 1, 1, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, -2, 1, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 2, -1, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, -1, 0, 0, 0);
    add_row(ROW_ITEM, OP_WRITE, 0, VALUE_MAX, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MAX, 0, 0, 0);
    add_row(ROW_ITEM, OP_SEARCH, 0, VALUE_MIN, 0, 0, 0);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      case (row.kind)
        ROW_SET_COUNT: begin
          write_register(COUNT_ADDR, 32'(row.value));
        end
        ROW_UNUSED_REG: begin
          write_register(UNUSED_REG_ADDR, 32'(row.value));
        end
        default: begin
          item.op = row.op;
          item.slot = row.slot;
          item.value = row.value;
          offer_item(item, row.typed, row.typed_rsp);
        end
      endcase
    end

    // Load the whole table in ascending order, from the minimum to the maximum,
    // with an occasional run of equal entries.
    write_register(COUNT_ADDR, 32'(TABLE_DEPTH));
    pick = VALUE_MIN;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      item.op = OP_WRITE;
      item.slot = i[SLOT_W-1:0];
      item.value = 32'((i == TABLE_DEPTH - 1) ? VALUE_MAX : pick);
      offer_item(item, 1'b0, no_rsp);
      if ($urandom_range(19) != 0) pick = pick + longint'($urandom_range(7000000, 1));
      if (pick > VALUE_MAX) pick = VALUE_MAX;
    end

    // Random phases, each under its own entry count.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin phase_count = 11'd1024; n_items = 100; end
        1: begin phase_count = 11'd2047; n_items = 70;  end
        2: begin phase_count = 11'd1025; n_items = 60;  end
        3: begin phase_count = 11'd1;    n_items = 40;  end
        4: begin phase_count = 11'd0;    n_items = 30;  end
        5: begin phase_count = 11'd2;    n_items = 40;  end
        6: begin phase_count = 11'($urandom_range(1023, 3)); n_items = 90; end
        7: begin phase_count = 11'd1024; n_items = 100; end
        default: begin phase_count = 11'($urandom_range(1024, 1)); n_items = 70; end
      endcase
      write_register(COUNT_ADDR, 32'(phase_count));
      phase_no = p;
      sender_idles = (p != QUIET_PHASE && p != HOLD_PHASE);
      eff = (phase_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(phase_count);

      for (int n = 0; n < n_items; n++) begin
        s = $urandom_range(TABLE_DEPTH - 1, 0);
        item.slot = s[SLOT_W-1:0];
        pick = $urandom_range(99);
        if (pick < 25) begin
          // Write that keeps the table in order: a value between the neighbors.
          lo_v = (s > 0) ? longint'(loaded_values[s-1]) : VALUE_MIN;
          hi_v = (s < TABLE_DEPTH - 1) ? longint'(loaded_values[s+1]) : VALUE_MAX;
          if (hi_v < lo_v) hi_v = lo_v;
          item.op = OP_WRITE;
          item.value = 32'(lo_v + longint'($urandom_range(32'(hi_v - lo_v), 0)));
        end else if (pick < 30) begin
          // Stray write that breaks the ordering.
          item.op = OP_WRITE;
          item.value = $urandom;
        end else begin
          item.op = OP_SEARCH;
          pick = $urandom_range(99);
          if (eff > 0 && pick < 55) begin
            item.value = loaded_values[$urandom_range(eff - 1, 0)];
          end else if (eff > 0 && pick < 75) begin
            item.value = loaded_values[$urandom_range(eff - 1, 0)]
                         + ($urandom_range(1) ? 32'sd1 : -32'sd1);
          end else if (pick < 85) begin
            case ($urandom_range(3))
              0: item.value = 32'(VALUE_MIN);
              1: item.value = 32'(VALUE_MAX);
              2: item.value = 32'sd0;
              default: item.value = -32'sd1;
            endcase
          end else begin
            item.value = $urandom;
          end
        end
        offer_item(item, 1'b0, no_rsp);
      end
    end

    // Let every outstanding search come back, then give the block time to go quiet.
    req_valid <= 1'b0;
    while (search_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (search_outcomes.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", search_outcomes.size()));
    end
    if (mismatches == 0) begin
      $display("sorted_table_binary_search_top regression: pass");
    end else begin
      $display("sorted_table_binary_search_top regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/stbs_pkg.sv
rtl/core/stbs_front.sv
rtl/core/stbs_back.sv
rtl/core/sorted_table_binary_search_top.sv
test/tb_sorted_table_binary_search_top.sv
